[sv/trs_tmb_pkg.sv]
// Shared constants, types and table-building functions for the TRS matrix builder.
// Used by trs_tmb_trig, trs_tmb_matrix and the top level; depends on nothing.
package trs_tmb_pkg;

  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int MAG_W = 15;      // table entry, 0..16384
  localparam int TRIG_W = 16;     // signed Q1.14
  localparam int SCALE_W = 16;    // signed Q4.12
  localparam int SHIFT_W = 32;    // signed Q16.16
  localparam int ANGLE_W = 16;
  localparam int PAIR_W = 30;     // product of two trig values
  localparam int TRIPLE_W = 44;   // product of three trig values
  localparam int ROT_W = 46;      // rotation entry, Q42
  localparam int PROD_W = 62;     // rotation entry times scale, Q54
  localparam int OUT_W = 24;      // signed Q8.16
  localparam int FRAC_DROP = 38;  // Q54 to Q16
  localparam int SERIES_TERMS = 10;
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
  localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'h4000;

  typedef logic [MAG_W-1:0] sine_rom_t [0:SINE_TABLE_DEPTH];

  // Quarter-wave sine in Q1.14 from a truncated Taylor series in Q30.
  function automatic logic [MAG_W-1:0] quarter_entry(input int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] r;
    x = (PI_HALF_Q30 * 64'(k) + 64'(SINE_TABLE_DEPTH / 2)) / 64'(SINE_TABLE_DEPTH);
    x2 = (x * x) >> 30;
    term = x;
    sum = x;
    for (int unsigned n = 1; n <= SERIES_TERMS; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    r = (sum + 64'd32768) >> 16;
    if (r > 64'd16384) begin
      r = 64'd16384;
    end
    return r[MAG_W-1:0];
  endfunction

  function automatic sine_rom_t build_sine_table();
    sine_rom_t t;
    for (int unsigned k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      t[k] = quarter_entry(k);
    end
    return t;
  endfunction

  // Table address for an angle: mirror in odd quadrants.
  function automatic logic [IDX_W-1:0] trig_index(input logic [ANGLE_W-1:0] a);
    logic [14+IDX_W-1:0] scaled;
    logic [IDX_W-1:0] idx;
    scaled = {{IDX_W{1'b0}}, a[13:0]} * (14 + IDX_W)'(SINE_TABLE_DEPTH);
    idx = scaled[14 +: IDX_W];
    return a[14] ? (IDX_W'(SINE_TABLE_DEPTH) - idx) : idx;
  endfunction

endpackage

[sv/trs_tmb_trig.sv]
// Sine and cosine of one binary angle: quarter-wave ROM lookup, then sign.
// Two register stages; uses trs_tmb_pkg for the table contents and addressing.
module trs_tmb_trig (
  input  logic                                     clk,
  input  logic [trs_tmb_pkg::ANGLE_W-1:0]          angle,
  output logic signed [trs_tmb_pkg::TRIG_W-1:0]    sin_o,
  output logic signed [trs_tmb_pkg::TRIG_W-1:0]    cos_o
);

  localparam trs_tmb_pkg::sine_rom_t SineRom = trs_tmb_pkg::build_sine_table();

  logic [trs_tmb_pkg::ANGLE_W-1:0] cos_angle;
  logic [trs_tmb_pkg::IDX_W-1:0]   sin_addr;
  logic [trs_tmb_pkg::IDX_W-1:0]   cos_addr;
  logic [trs_tmb_pkg::MAG_W-1:0]   sin_mag_r;
  logic [trs_tmb_pkg::MAG_W-1:0]   cos_mag_r;
  logic                            sin_neg_r;
  logic                            cos_neg_r;
  logic signed [trs_tmb_pkg::TRIG_W-1:0] sin_r;
  logic signed [trs_tmb_pkg::TRIG_W-1:0] cos_r;

  assign cos_angle = angle + trs_tmb_pkg::QUARTER_TURN;
  assign sin_addr  = trs_tmb_pkg::trig_index(angle);
  assign cos_addr  = trs_tmb_pkg::trig_index(cos_angle);

  always_ff @(posedge clk) begin
    sin_mag_r <= SineRom[sin_addr];
    cos_mag_r <= SineRom[cos_addr];
    sin_neg_r <= angle[15];
    cos_neg_r <= cos_angle[15];
  end

  // Negate in the lower half turn.
  always_ff @(posedge clk) begin
    sin_r <= sin_neg_r ? -$signed({1'b0, sin_mag_r}) : $signed({1'b0, sin_mag_r});
    cos_r <= cos_neg_r ? -$signed({1'b0, cos_mag_r}) : $signed({1'b0, cos_mag_r});
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

[sv/trs_tmb_matrix.sv]
// Rotation Rz*Ry*Rx times column scale, rounded to Q8.16: five register stages.
// Uses trs_tmb_pkg widths; fed with signed trig values from trs_tmb_trig.
module trs_tmb_matrix (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  input  logic signed [trs_tmb_pkg::TRIG_W-1:0]     sx,
  input  logic signed [trs_tmb_pkg::TRIG_W-1:0]     cx,
  input  logic signed [trs_tmb_pkg::TRIG_W-1:0]     sy,
  input  logic signed [trs_tmb_pkg::TRIG_W-1:0]     cy,
  input  logic signed [trs_tmb_pkg::TRIG_W-1:0]     sz,
  input  logic signed [trs_tmb_pkg::TRIG_W-1:0]     cz,
  input  logic signed [trs_tmb_pkg::SCALE_W-1:0]    scale [3],
  output logic                                      out_valid,
  output logic signed [trs_tmb_pkg::OUT_W-1:0]      m [9]
);

  localparam int PW = trs_tmb_pkg::PAIR_W;
  localparam int TW = trs_tmb_pkg::TRIPLE_W;
  localparam int RW = trs_tmb_pkg::ROT_W;
  localparam int XW = trs_tmb_pkg::PROD_W;

  logic [4:0] v_r;

  // stage 3: pair products
  logic signed [PW-1:0] czcy_r, czsy_r, szcx_r, szsy_r, czcx_r;
  logic signed [PW-1:0] czsx_r, szsx_r, szcy_r, cysx_r, cycx_r;
  logic signed [trs_tmb_pkg::TRIG_W-1:0] sx3_r, cx3_r, sy3_r;
  // stage 4: triple products
  logic signed [TW-1:0] t1_r, t2_r, t4_r, t5_r;
  logic signed [PW-1:0] czcy4_r, szcx4_r, szsx4_r, szcy4_r, czcx4_r;
  logic signed [PW-1:0] czsx4_r, cysx4_r, cycx4_r;
  logic signed [trs_tmb_pkg::TRIG_W-1:0] sy4_r;
  // stage 5: rotation entries, stage 6: scaled, stage 7: rounded
  logic signed [RW-1:0] rot_r [9];
  logic signed [XW-1:0] prod_r [9];
  logic signed [XW-1:0] biased [9];
  logic signed [trs_tmb_pkg::OUT_W-1:0] m_r [9];
  logic signed [trs_tmb_pkg::SCALE_W-1:0] sc3_r [3];
  logic signed [trs_tmb_pkg::SCALE_W-1:0] sc4_r [3];
  logic signed [trs_tmb_pkg::SCALE_W-1:0] sc5_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    czcy_r <= PW'(cz * cy);
    czsy_r <= PW'(cz * sy);
    szcx_r <= PW'(sz * cx);
    szsy_r <= PW'(sz * sy);
    czcx_r <= PW'(cz * cx);
    czsx_r <= PW'(cz * sx);
    szsx_r <= PW'(sz * sx);
    szcy_r <= PW'(sz * cy);
    cysx_r <= PW'(cy * sx);
    cycx_r <= PW'(cy * cx);
    sx3_r  <= sx;
    cx3_r  <= cx;
    sy3_r  <= sy;
    sc3_r  <= scale;
  end

  always_ff @(posedge clk) begin
    t1_r    <= TW'(czsy_r * sx3_r);
    t2_r    <= TW'(czsy_r * cx3_r);
    t4_r    <= TW'(szsy_r * sx3_r);
    t5_r    <= TW'(szsy_r * cx3_r);
    czcy4_r <= czcy_r;
    szcx4_r <= szcx_r;
    szsx4_r <= szsx_r;
    szcy4_r <= szcy_r;
    czcx4_r <= czcx_r;
    czsx4_r <= czsx_r;
    cysx4_r <= cysx_r;
    cycx4_r <= cycx_r;
    sy4_r   <= sy3_r;
    sc4_r   <= sc3_r;
  end

  // Bring every entry to Q42: a pair product gains one unit factor, sy two.
  always_ff @(posedge clk) begin
    rot_r[0] <= RW'(czcy4_r) <<< 14;
    rot_r[1] <= -RW'(t1_r) - (RW'(szcx4_r) <<< 14);
    rot_r[2] <= -RW'(t2_r) + (RW'(szsx4_r) <<< 14);
    rot_r[3] <= RW'(szcy4_r) <<< 14;
    rot_r[4] <= -RW'(t4_r) + (RW'(czcx4_r) <<< 14);
    rot_r[5] <= -RW'(t5_r) - (RW'(czsx4_r) <<< 14);
    rot_r[6] <= RW'(sy4_r) <<< 28;
    rot_r[7] <= RW'(cysx4_r) <<< 14;
    rot_r[8] <= RW'(cycx4_r) <<< 14;
    sc5_r    <= sc4_r;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 9; i++) begin
      prod_r[i] <= XW'(rot_r[i]) * XW'(sc5_r[i % 3]);
    end
  end

  // Round half up; every entry stays within +-16, so the top bits always fit.
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      biased[i] = prod_r[i] + (XW'(1) <<< (trs_tmb_pkg::FRAC_DROP - 1));
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 9; i++) begin
      m_r[i] <= biased[i][trs_tmb_pkg::FRAC_DROP +: trs_tmb_pkg::OUT_W];
    end
  end

  assign out_valid = v_r[4];
  assign m = m_r;

endmodule

[sv/trs_transform_matrix_builder_core.sv]
// TRS affine matrix builder, top level: trig lookup and matrix pipeline.
// Depends on trs_tmb_pkg, trs_tmb_trig and trs_tmb_matrix.
//
// Usage: drive the translation, three binary angles and three Q4.12 scales
// on the in_ ports and raise start. An item is accepted at every rising edge
// with start high and busy low; busy is never raised, so one item can enter
// every cycle. Results leave on the out_ ports, marked by out_valid for one
// cycle: nine Q8.16 linear entries and the translation column unchanged.
// Throughput is one item per cycle through the seven-stage pipeline: two
// stages for the sine ROM read and sign, then pair products, triple
// products, sums, scale product and rounding, each a register stage.
// Reset (rst_n low, synchronous) clears the valid bits, dropping items in
// flight; payload registers are not reset. The receiver cannot stall:
// every result is shown for exactly one cycle.
module trs_transform_matrix_builder_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [trs_tmb_pkg::SHIFT_W-1:0] in_shift_x,
  input  logic signed [trs_tmb_pkg::SHIFT_W-1:0] in_shift_y,
  input  logic signed [trs_tmb_pkg::SHIFT_W-1:0] in_shift_z,
  input  logic [trs_tmb_pkg::ANGLE_W-1:0]        in_angle_x,
  input  logic [trs_tmb_pkg::ANGLE_W-1:0]        in_angle_y,
  input  logic [trs_tmb_pkg::ANGLE_W-1:0]        in_angle_z,
  input  logic signed [trs_tmb_pkg::SCALE_W-1:0] in_scale_x,
  input  logic signed [trs_tmb_pkg::SCALE_W-1:0] in_scale_y,
  input  logic signed [trs_tmb_pkg::SCALE_W-1:0] in_scale_z,
  output logic                                   out_valid,
  output logic signed [trs_tmb_pkg::OUT_W-1:0]   out_m00,
  output logic signed [trs_tmb_pkg::OUT_W-1:0]   out_m01,
  output logic signed [trs_tmb_pkg::OUT_W-1:0]   out_m02,
  output logic signed [trs_tmb_pkg::OUT_W-1:0]   out_m10,
  output logic signed [trs_tmb_pkg::OUT_W-1:0]   out_m11,
  output logic signed [trs_tmb_pkg::OUT_W-1:0]   out_m12,
  output logic signed [trs_tmb_pkg::OUT_W-1:0]   out_m20,
  output logic signed [trs_tmb_pkg::OUT_W-1:0]   out_m21,
  output logic signed [trs_tmb_pkg::OUT_W-1:0]   out_m22,
  output logic signed [trs_tmb_pkg::SHIFT_W-1:0] out_tx,
  output logic signed [trs_tmb_pkg::SHIFT_W-1:0] out_ty,
  output logic signed [trs_tmb_pkg::SHIFT_W-1:0] out_tz
);

  localparam int LATENCY = 7;

  logic accept;
  logic [1:0] v_r;
  logic signed [trs_tmb_pkg::SCALE_W-1:0] sc1_r [3];
  logic signed [trs_tmb_pkg::SCALE_W-1:0] sc2_r [3];
  logic signed [trs_tmb_pkg::SHIFT_W-1:0] tx_r [LATENCY];
  logic signed [trs_tmb_pkg::SHIFT_W-1:0] ty_r [LATENCY];
  logic signed [trs_tmb_pkg::SHIFT_W-1:0] tz_r [LATENCY];
  logic signed [trs_tmb_pkg::TRIG_W-1:0] sx, cx, sy, cy, sz, cz;
  logic signed [trs_tmb_pkg::OUT_W-1:0] m [9];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[0], accept};
    end
  end

  // Hold scales alongside the trig stages and translation alongside the whole pipeline.
  always_ff @(posedge clk) begin
    sc1_r <= '{in_scale_x, in_scale_y, in_scale_z};
    sc2_r <= sc1_r;
    tx_r[0] <= in_shift_x;
    ty_r[0] <= in_shift_y;
    tz_r[0] <= in_shift_z;
    for (int i = 1; i < LATENCY; i++) begin
      tx_r[i] <= tx_r[i-1];
      ty_r[i] <= ty_r[i-1];
      tz_r[i] <= tz_r[i-1];
    end
  end

  trs_tmb_trig u_trig_x (.clk(clk), .angle(in_angle_x), .sin_o(sx), .cos_o(cx));
  trs_tmb_trig u_trig_y (.clk(clk), .angle(in_angle_y), .sin_o(sy), .cos_o(cy));
  trs_tmb_trig u_trig_z (.clk(clk), .angle(in_angle_z), .sin_o(sz), .cos_o(cz));

  trs_tmb_matrix u_matrix (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v_r[1]),
    .sx        (sx),
    .cx        (cx),
    .sy        (sy),
    .cy        (cy),
    .sz        (sz),
    .cz        (cz),
    .scale     (sc2_r),
    .out_valid (out_valid),
    .m         (m)
  );

  assign out_m00 = m[0];
  assign out_m01 = m[1];
  assign out_m02 = m[2];
  assign out_m10 = m[3];
  assign out_m11 = m[4];
  assign out_m12 = m[5];
  assign out_m20 = m[6];
  assign out_m21 = m[7];
  assign out_m22 = m[8];
  assign out_tx  = tx_r[LATENCY-1];
  assign out_ty  = ty_r[LATENCY-1];
  assign out_tz  = tz_r[LATENCY-1];

  a_result_follows_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LATENCY))
    else $error("result without an accepted item");

  a_item_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##(LATENCY) out_valid)
    else $error("accepted item produced no result");

  a_translation_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_tx == $past(in_shift_x, LATENCY)) &&
                  (out_tz == $past(in_shift_z, LATENCY)))
    else $error("translation column out of step with matrix");

  a_row2_col0_scale_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ($past(in_scale_x, LATENCY) == '0) |-> (out_m00 == '0) &&
      (out_m10 == '0) && (out_m20 == '0))
    else $error("zero scale did not clear its column");

endmodule
